// ----- hdl/ssc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the stack-sortable sequence checker.
// Holds capacity constants, derived widths and the controller/datapath structs.
// No dependencies.
package ssc_pkg;

    // Capacity: items per sequence and side stack depth.
    localparam int MAX_ITEMS = 1024;

    // Width of an item number field.
    localparam int ITEM_W = 11;

    // Stack pointer and item counter hold 0..MAX_ITEMS.
    localparam int SP_W = $clog2(MAX_ITEMS + 1);

    // Stack memory address.
    localparam int AW = $clog2(MAX_ITEMS);

    // Expected number runs 1..MAX_ITEMS+1.
    localparam int CNT_W = $clog2(MAX_ITEMS + 2);

    // Common width for comparing item numbers against the expected number.
    localparam int CMP_W = (ITEM_W > CNT_W) ? ITEM_W : CNT_W;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture input beat
        logic count;    // bump items seen
        logic set_ovf;  // mark overflow
        logic rd_en;    // read stack top into the read register
        logic pop;      // drop top, advance expected number
        logic advance;  // advance expected number on matching item
        logic push;     // push held item
        logic emit;     // load result register and clear sequence state
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic cnt_full;   // MAX_ITEMS items already counted
        logic sp_zero;    // stack empty
        logic sp_full;    // stack holds MAX_ITEMS entries
        logic top_match;  // registered top equals expected number
        logic item_match; // held item equals expected number
        logic last;       // held item closes the sequence
        logic out_busy;   // result register still occupied next cycle
    } t_dp_stat;

endpackage

// ----- hdl/ssc_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for item beats and result beats.
// Depends on ssc_pkg for field widths.
interface ssc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ssc_pkg::ITEM_W-1:0]  item_number;
    logic                        last_item;

    modport source (output valid, output item_number, output last_item, input ready);
    modport sink   (input valid, input item_number, input last_item, output ready);
endinterface

interface ssc_out_if;
    logic valid;
    logic ready;
    logic feasible;
    logic overflow;

    modport source (output valid, output feasible, output overflow, input ready);
    modport sink   (input valid, input feasible, input overflow, output ready);
endinterface

// ----- hdl/ssc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: side stack memory, pointer, expected number, item count, result register.
// Depends on ssc_pkg; driven by ssc_ctrl through t_dp_cmd.
module ssc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssc_pkg::t_dp_cmd            i_cmd,
    output ssc_pkg::t_dp_stat           o_stat,
    input  logic [ssc_pkg::ITEM_W-1:0]  i_item,
    input  logic                        i_last,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_feasible,
    output logic                        o_overflow
);
    import ssc_pkg::*;

    logic [ITEM_W-1:0] r_mem [MAX_ITEMS];
    logic [ITEM_W-1:0] r_rdata;
    logic [ITEM_W-1:0] r_item;
    logic              r_last;
    logic [SP_W-1:0]   r_sp;
    logic [CNT_W-1:0]  r_exp;
    logic [SP_W-1:0]   r_seen;
    logic              r_ovf;
    logic              r_out_valid;
    logic              r_feasible;
    logic              r_overflow;

    logic [AW-1:0]     w_top_addr;
    logic [SP_W-1:0]   w_sp_dec;
    logic              w_feasible;

    assign w_sp_dec   = r_sp - SP_W'(1);
    assign w_top_addr = w_sp_dec[AW-1:0];
    assign w_feasible = !r_ovf && (r_exp == (CNT_W'(r_seen) + CNT_W'(1)));

    always_comb begin
        o_stat            = '0;
        o_stat.cnt_full   = (r_seen == SP_W'(MAX_ITEMS));
        o_stat.sp_zero    = (r_sp == '0);
        o_stat.sp_full    = (r_sp == SP_W'(MAX_ITEMS));
        o_stat.top_match  = (CMP_W'(r_rdata) == CMP_W'(r_exp));
        o_stat.item_match = (CMP_W'(r_item) == CMP_W'(r_exp));
        o_stat.last       = r_last;
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    // Stack memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_sp[AW-1:0]] <= r_item;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_top_addr];
        end
    end

    // Held input beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_last <= i_last;
        end
    end

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_sp   <= '0;
            r_exp  <= CNT_W'(1);
            r_seen <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.count) begin
                r_seen <= r_seen + SP_W'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_sp  <= w_sp_dec;
                r_exp <= r_exp + CNT_W'(1);
            end else if (i_cmd.advance) begin
                r_exp <= r_exp + CNT_W'(1);
            end else if (i_cmd.push) begin
                r_sp <= r_sp + SP_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_feasible <= w_feasible;
            r_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_feasible  = r_feasible;
    assign o_overflow  = r_overflow;

endmodule

// ----- hdl/ssc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences accept, stack drain, match/push and result emission.
// Depends on ssc_pkg; drives ssc_datapath through t_dp_cmd.
module ssc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  ssc_pkg::t_dp_stat  i_stat,
    output ssc_pkg::t_dp_cmd   o_cmd
);
    import ssc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ACT,
        S_FIN_RD,
        S_FIN_CMP,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.cnt_full) begin
                        // Count full: ignore the item, keep its last flag.
                        o_cmd.set_ovf = 1'b1;
                        n_state       = i_in_last ? S_FIN_RD : S_IDLE;
                    end else begin
                        o_cmd.count = 1'b1;
                        n_state     = S_RD;
                    end
                end
            end
            S_RD: begin
                if (i_stat.sp_zero) begin
                    n_state = S_ACT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.top_match) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RD;
                end else begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (i_stat.item_match) begin
                    o_cmd.advance = 1'b1;
                end else if (i_stat.sp_full) begin
                    o_cmd.set_ovf = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                end
                n_state = i_stat.last ? S_FIN_RD : S_IDLE;
            end
            S_FIN_RD: begin
                if (i_stat.sp_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FIN_CMP;
                end
            end
            S_FIN_CMP: begin
                if (i_stat.top_match) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_FIN_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/stack_sortable_sequence_check_top.sv -----
`timescale 1ns / 1ps
// Stack-sortable sequence checker. Item numbers arrive one beat at a time on i_in;
// a beat with last_item set closes the sequence and produces one result beat on o_out
// (feasible, overflow), after which the checker is ready for a new sequence. Items
// are routed through a side stack held in a MAX_ITEMS-entry memory; before each item
// the stack is drained while its top equals the next expected number. An item is
// accepted, then the stack top is read and compared unless the stack is empty, and
// every match pops the entry and reads again: each pop is one memory read and one
// compare, so the memory read port sets the pace. The item then advances, is pushed or
// marks overflow; a last item adds the final drain and a step to load the result
// register. The result register decouples the output: a waiting result only stalls
// the next sequence's end, not its items. Memory contents need no clearing after
// reset; only entries below the stack pointer are read.
// Depends on ssc_pkg, ssc_if, ssc_ctrl and ssc_datapath.
module stack_sortable_sequence_check_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_in_if.sink    i_in,
    ssc_out_if.source o_out
);
    import ssc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Controller: owns the handshake on the input side and the step sequence.
    ssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_item),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: stack, counters and the result register feeding o_out.
    ssc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_item      (i_in.item_number),
        .i_last      (i_in.last_item),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_feasible  (o_out.feasible),
        .o_overflow  (o_out.overflow)
    );

endmodule

// ----- hdl/ssc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the stack-sortable sequence checker, bound to the top level.
// Watches only the top-level handshake and payload ports.
module ssc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_feasible,
    input logic i_overflow
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid && i_in_ready;

    // Hold a pending result until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    // An overflowed sequence never reports feasible.
    a_ovf_infeasible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_feasible && i_overflow))
        else $error("feasible reported together with overflow");

    // Input is not ready in the cycle after a beat that closes a sequence.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_in_last |=> !i_in_ready)
        else $error("input ready directly after a closing item");

    // No result straight out of reset.
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind stack_sortable_sequence_check_top ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_item),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_feasible  (o_out.feasible),
    .i_overflow  (o_out.overflow)
);

// ----- tb/ssc_verdict_checker.sv -----
`timescale 1ns / 1ps
// Verdict checker for the stack-sortable sequence checker: watches both channels,
// predicts each verdict from the accepted item beats and compares in order.
// Depends on ssc_pkg and the ssc_in_if / ssc_out_if interfaces.
module ssc_verdict_checker
    import ssc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ssc_in_if    i_items,
    ssc_out_if   i_results,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic feasible;
        logic overflow;
    } t_verdict;

    // Predicted sequence state.
    logic [ITEM_W-1:0] pend_stack [MAX_ITEMS];
    logic [SP_W-1:0]   stack_depth;
    logic [CNT_W-1:0]  next_num;
    logic [SP_W-1:0]   seq_count;
    logic              seq_ovf;

    t_verdict          verdict_q [$];

    task automatic clear_sequence();
        stack_depth = '0;
        next_num    = CNT_W'(1);
        seq_count   = '0;
        seq_ovf     = 1'b0;
    endtask

    // Retire stack tops while they carry the next number in order.
    task automatic retire_stack_tops();
        while (stack_depth != '0 &&
               CMP_W'(pend_stack[AW'(stack_depth - 1'b1)]) == CMP_W'(next_num)) begin
            stack_depth = stack_depth - 1'b1;
            next_num    = next_num + 1'b1;
        end
    endtask

    task automatic take_item(input logic [ITEM_W-1:0] num, input logic last);
        t_verdict v;
        if (seq_count >= SP_W'(MAX_ITEMS)) begin
            // count full: the beat only marks overflow (and may end the sequence)
            seq_ovf = 1'b1;
        end else begin
            seq_count = seq_count + 1'b1;
            retire_stack_tops();
            if (CMP_W'(num) == CMP_W'(next_num)) begin
                next_num = next_num + 1'b1;
            end else if (stack_depth < SP_W'(MAX_ITEMS)) begin
                pend_stack[AW'(stack_depth)] = num;
                stack_depth = stack_depth + 1'b1;
            end else begin
                seq_ovf = 1'b1;
            end
        end
        if (last) begin
            retire_stack_tops();
            v.feasible = !seq_ovf && (int'(next_num) == int'(seq_count) + 1);
            v.overflow = seq_ovf;
            verdict_q.push_back(v);
            clear_sequence();
        end
    endtask

    task automatic check_verdict(input logic feasible, input logic overflow);
        t_verdict want;
        if (verdict_q.size() == 0) begin
            if (o_errors < 10)
                $display("[%0t] verdict with no sequence pending: feasible=%0b overflow=%0b",
                         $time, feasible, overflow);
            o_errors = o_errors + 1;
        end else begin
            want = verdict_q.pop_front();
            if (want.feasible !== feasible || want.overflow !== overflow) begin
                if (o_errors < 10)
                    $display("[%0t] verdict mismatch: expected feasible=%0b overflow=%0b, got feasible=%0b overflow=%0b",
                             $time, want.feasible, want.overflow, feasible, overflow);
                o_errors = o_errors + 1;
            end
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sequence();
            verdict_q.delete();
        end else begin
            if (i_results.valid && i_results.ready)
                check_verdict(i_results.feasible, i_results.overflow);
            if (i_items.valid && i_items.ready)
                take_item(i_items.item_number, i_items.last_item);
        end
        o_pending = verdict_q.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the stack-sortable sequence checker: drives item sequences,
// throttles the result channel and reports the verdict.
// Depends on ssc_pkg, ssc_if, the checker RTL and ssc_verdict_checker.
module tb;
    import ssc_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    int   errs;
    int   pend;

    // Idle rates in percent: sender gaps between beats, receiver ready drops.
    int   src_idle;
    int   rcv_idle;

    // Items of the sequence being built, and beats sent in the random part.
    logic [ITEM_W-1:0] seq_buf [$];
    int                sent;

    ssc_in_if  in_bus ();
    ssc_out_if out_bus ();

    stack_sortable_sequence_check_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    ssc_verdict_checker u_chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_items   (in_bus),
        .i_results (out_bus),
        .o_errors  (errs),
        .o_pending (pend)
    );

    // 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drop ready at random on the result side; change only on falling edges.
    always @(negedge clk) begin
        out_bus.ready <= ($urandom_range(99, 0) >= rcv_idle);
    end

    // Hold one item beat until it is taken. Enter and leave on a falling edge.
    task automatic send_item(input logic [ITEM_W-1:0] num, input logic last);
        while ($urandom_range(99, 0) < src_idle) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.item_number <= num;
        in_bus.last_item   <= last;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Send the built sequence, last flag on its final beat, then clear it.
    task automatic send_sequence();
        for (int i = 0; i < seq_buf.size(); i++)
            send_item(seq_buf[i], i == seq_buf.size() - 1);
        sent += seq_buf.size();
        seq_buf.delete();
    endtask

    // Drop valid and hold off until every pending verdict has come back.
    task automatic hold_until_drained();
        in_bus.valid <= 1'b0;
        @(negedge clk);
        while (pend != 0) @(negedge clk);
    endtask

    // Build a 231-avoiding arrangement of lo..hi: the largest value splits it
    // into a lower part before it and a higher part after it.
    function automatic void add_sortable(int lo, int hi);
        int split;
        if (lo > hi) return;
        split = $urandom_range(hi, lo);
        add_sortable(lo, split - 1);
        seq_buf.push_back(ITEM_W'(hi));
        add_sortable(split, hi - 1);
    endfunction

    // Uniform shuffle of 1..n; often not sortable once n grows past a few.
    function automatic void add_shuffle(int n);
        int j;
        logic [ITEM_W-1:0] t;
        for (int i = 1; i <= n; i++) seq_buf.push_back(ITEM_W'(i));
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            t = seq_buf[i];
            seq_buf[i] = seq_buf[j];
            seq_buf[j] = t;
        end
    endfunction

    function automatic int pick_length();
        if ($urandom_range(9, 0) == 0) return $urandom_range(64, 11);
        return $urandom_range(10, 1);
    endfunction

    // One random sequence: mostly well formed, some damaged, some noise.
    task automatic send_random_sequence();
        int n;
        int kind;
        int pos;
        n    = pick_length();
        kind = $urandom_range(99, 0);
        if (kind < 45) begin
            add_sortable(1, n);
        end else if (kind < 70) begin
            add_shuffle(n);
        end else if (kind < 85) begin
            // damage a sortable sequence: wild value, duplicate, missing or extra item
            add_sortable(1, n);
            pos = $urandom_range(n - 1, 0);
            case ($urandom_range(3, 0))
                0: seq_buf[pos] = ITEM_W'($urandom_range(2047, 0));
                1: seq_buf[pos] = seq_buf[$urandom_range(n - 1, 0)];
                2: if (n > 1) seq_buf.delete(pos);
                default: seq_buf.insert(pos, ITEM_W'($urandom_range(n + 1, 0)));
            endcase
        end else begin
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1, 0) == 1)
                    seq_buf.push_back(ITEM_W'($urandom_range(2047, 0)));
                else
                    seq_buf.push_back(ITEM_W'($urandom_range(n + 2, 0)));
            end
        end
        send_sequence();
    endtask

    task automatic random_phase(input int beats);
        sent = 0;
        while (sent < beats) send_random_sequence();
    endtask

    task automatic directed_part();
        // single items: in order, zero, all ones, top of range
        seq_buf = '{ITEM_W'(1)};    send_sequence();
        seq_buf = '{ITEM_W'(0)};    send_sequence();
        seq_buf = '{ITEM_W'(2047)}; send_sequence();
        seq_buf = '{ITEM_W'(1024)}; send_sequence();
        // swap through the stack, and a plain reversal
        seq_buf = '{ITEM_W'(2), ITEM_W'(1)};               send_sequence();
        seq_buf = '{ITEM_W'(3), ITEM_W'(2), ITEM_W'(1)};   send_sequence();
        // matching top left behind until the final drain
        seq_buf = '{ITEM_W'(3), ITEM_W'(1), ITEM_W'(2)};   send_sequence();
        // the one forbidden pattern
        seq_buf = '{ITEM_W'(2), ITEM_W'(3), ITEM_W'(1)};   send_sequence();
        // duplicate number
        seq_buf = '{ITEM_W'(1), ITEM_W'(1)};               send_sequence();
        // stack top retired before the arriving item is compared
        seq_buf = '{ITEM_W'(2), ITEM_W'(1), ITEM_W'(3)};   send_sequence();
        // zero in the middle of an otherwise clean run
        seq_buf = '{ITEM_W'(1), ITEM_W'(0), ITEM_W'(2)};   send_sequence();
    endtask

    // Capacity edges: a full-length reversal fills the stack almost to the top,
    // a few beats past the count limit follow, and the closing beat is one of
    // them, so the final drain walks the whole stack.
    task automatic capacity_part();
        for (int i = MAX_ITEMS; i >= 1; i--) seq_buf.push_back(ITEM_W'(i));
        for (int i = 0; i < 6; i++) seq_buf.push_back(ITEM_W'($urandom_range(2047, 0)));
        send_sequence();
    endtask

    initial begin
        rst_n              = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.item_number = '0;
        in_bus.last_item   = 1'b0;
        out_bus.ready      = 1'b0;
        src_idle           = 31;
        rcv_idle           = 87;

        // hold reset, release on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 1: sparse sender gaps, receiver mostly stalled
        directed_part();
        random_phase(320);
        hold_until_drained();

        // phase 2: swap the pressure around
        src_idle = 87;
        rcv_idle = 31;
        random_phase(320);
        hold_until_drained();

        // phase 3: full rate both ways, plus the long capacity run
        src_idle = 0;
        rcv_idle = 0;
        capacity_part();
        random_phase(320);

        // drain: wait for the last verdicts, then let the block settle
        in_bus.valid <= 1'b0;
        @(negedge clk);
        while (pend != 0) @(negedge clk);
        repeat (40) @(negedge clk);

        if (errs == 0 && pend == 0) begin
            $display("** stack_sortable_sequence_check_top: PASSED **");
        end else begin
            $display("** stack_sortable_sequence_check_top: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("** stack_sortable_sequence_check_top: FAILED **");
        $finish;
    end

endmodule
